@@ src/satq_pkg.sv @@
// ----------------------------------------------------------------------------
// satq_pkg: shared types and constants of the sorted alarm timer queue
// Entry and result word layouts, status and operation codes, sequencer states.
// ----------------------------------------------------------------------------
package satq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_OUT         = 16;
  localparam int NW              = $clog2(MAX_OUT + 1);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef enum logic [1:0] {
    ST_QUEUED  = 2'd0,
    ST_FIRED   = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

  typedef struct packed {
    logic [31:0] deadline;
    logic [15:0] tag;
    logic [15:0] delay;
  } entry_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] tag;
    logic [15:0] delay;
    logic        last;
  } res_t;

  typedef struct packed {
    logic vld;
    res_t res;
  } emit_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PUT,
    S_EMIT,
    S_TK_CMP,
    S_TK_FLUSH
  } state_t;

endpackage

@@ src/sorted_alarm_timer_queue_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_alarm_timer_queue_unit: sorted timer queue of pending alarms
// Inserts alarms by deadline and fires the due ones on each one-second tick.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Word contents (lowest bit first)
//  -------  ---------  --------------------------------------------------
//  in_      slave      tuser: operation; tdata: delay_seconds, alarm_tag
//  out_     master     tuser: status; tdata: fired_tag, fired_delay;
//                      tlast: last_result
//
// One item is worked on at a time. An insert that lands at the tail of the
// queue passes one compare step and the emit state on its way to the output
// register; every later entry that has to move down one slot adds a compare
// step, since the entry store is read and written once per cycle while the
// walk goes back from the tail. A tick on an empty queue stays idle, one
// with nothing due ends after its compare step, and one that fires alarms
// pops them in the compare state and hands the last over from the flush
// state. Rejected and zero-delay inserts go straight to the emit state.
// Reset is synchronous and needs no clearing pass: the store is only read
// below the entry count. A stalled output only holds the sequencer when it
// has a new word to hand over; the output register keeps the waiting word.
//
// Entries live in a ring inside the store. The head pointer moves on a pop,
// so firing costs no shifting; an insert shifts only the entries after the
// new one. Up to sixteen alarms fire per tick, the rest fire on later ticks.
module sorted_alarm_timer_queue_unit #(
  parameter int QUEUE_DEPTH = satq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] delay_seconds, [31:16] alarm_tag
  input  logic [0:0]  in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] fired_tag, [31:16] fired_delay
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast   // last_result
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  satq_pkg::emit_t  emit;
  logic             out_free;
  logic             out_valid_r;
  satq_pkg::res_t   out_word_r;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  satq_pkg::entry_t wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  satq_pkg::entry_t rd_data;

  // The output register may take a new word when empty or when its word
  // leaves in this cycle.
  assign out_free = !out_valid_r || out_tready;

  satq_ctrl #(
    .DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (in_tuser[0]),
    .in_delay (in_tdata[15:0]),
    .in_tag   (in_tdata[31:16]),
    .out_free (out_free),
    .emit     (emit),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  satq_ram #(
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Output register: control bit under reset, payload without.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit.vld) begin
      out_word_r <= emit.res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_word_r.delay, out_word_r.tag};
  assign out_tuser  = out_word_r.status;
  assign out_tlast  = out_word_r.last;

endmodule

@@ src/satq_ram.sv @@
// ----------------------------------------------------------------------------
// satq_ram: entry store of the timer queue
// One write port and one read port; read data is registered and holds its
// value in cycles without a read.
// ----------------------------------------------------------------------------
module satq_ram #(
  parameter int DEPTH = satq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  satq_pkg::entry_t         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output satq_pkg::entry_t         rd_data
);

  satq_pkg::entry_t mem [DEPTH];
  satq_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/satq_ctrl.sv @@
// ----------------------------------------------------------------------------
// satq_ctrl: sequencer of the timer queue
// Keeps the entries as a ring in the entry store, sorted from the head.
// Inserts walk back from the tail, shifting later entries by one slot;
// ticks pop due entries from the head.
// ----------------------------------------------------------------------------
module satq_ctrl #(
  parameter int DEPTH = satq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_op,
  input  logic [15:0]              in_delay,
  input  logic [15:0]              in_tag,
  input  logic                     out_free,
  output satq_pkg::emit_t          emit,
  output logic                     wr_en,
  output logic [$clog2(DEPTH)-1:0] wr_addr,
  output satq_pkg::entry_t         wr_data,
  output logic                     rd_en,
  output logic [$clog2(DEPTH)-1:0] rd_addr,
  input  satq_pkg::entry_t         rd_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  satq_pkg::state_t  state_r, state_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [31:0]       now_r, now_nxt;
  logic [31:0]       dl_r, dl_nxt;
  logic [15:0]       tag_r, tag_nxt;
  logic [15:0]       delay_r, delay_nxt;
  satq_pkg::status_t status_r, status_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [satq_pkg::NW-1:0] n_r, n_nxt;
  satq_pkg::entry_t  pend_r, pend_nxt;

  satq_pkg::entry_t  new_entry;
  logic              shift_on;
  logic              due;
  logic              pop;

  // Ring position of logical offset off from the head.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // a comes before b when a - b is negative as a signed 32-bit value.
  function automatic logic wrap_before(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  assign new_entry = '{deadline: dl_r, tag: tag_r, delay: delay_r};
  assign shift_on  = !wrap_before(rd_data.deadline, dl_r);
  assign due       = !wrap_before(now_r, rd_data.deadline);
  assign pop       = (state_r == satq_pkg::S_TK_CMP) && due &&
                     ((n_r == '0) || out_free);
  assign in_ready  = (state_r == satq_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= satq_pkg::S_IDLE;
      head_r  <= '0;
      count_r <= '0;
      now_r   <= '0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      now_r   <= now_nxt;
      n_r     <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dl_r     <= dl_nxt;
    tag_r    <= tag_nxt;
    delay_r  <= delay_nxt;
    status_r <= status_nxt;
    idx_r    <= idx_nxt;
    pend_r   <= pend_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    now_nxt    = now_r;
    dl_nxt     = dl_r;
    tag_nxt    = tag_r;
    delay_nxt  = delay_r;
    status_nxt = status_r;
    idx_nxt    = idx_r;
    n_nxt      = n_r;
    pend_nxt   = pend_r;
    wr_en      = 1'b0;
    wr_addr    = phys(head_r, idx_r);
    wr_data    = new_entry;
    rd_en      = 1'b0;
    rd_addr    = head_r;
    emit       = '0;

    case (state_r)
      satq_pkg::S_IDLE: begin
        if (in_valid) begin
          tag_nxt   = in_tag;
          delay_nxt = in_delay;
          dl_nxt    = now_r + {16'd0, in_delay};
          n_nxt     = '0;
          if (in_op == satq_pkg::OP_INSERT) begin
            if (in_delay == 16'd0) begin
              status_nxt = satq_pkg::ST_FIRED;
              state_nxt  = satq_pkg::S_EMIT;
            end else if (count_r == CW'(DEPTH)) begin
              status_nxt = satq_pkg::ST_DROPPED;
              state_nxt  = satq_pkg::S_EMIT;
            end else begin
              status_nxt = satq_pkg::ST_QUEUED;
              idx_nxt    = count_r[AW-1:0];
              if (count_r == '0) begin
                state_nxt = satq_pkg::S_INS_PUT;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = phys(head_r, AW'(count_r - CW'(1)));
                state_nxt = satq_pkg::S_INS_CMP;
              end
            end
          end else begin
            now_nxt = now_r + 32'd1;
            if (count_r != '0) begin
              rd_en     = 1'b1;
              rd_addr   = head_r;
              state_nxt = satq_pkg::S_TK_CMP;
            end
          end
        end
      end

      satq_pkg::S_INS_CMP: begin
        // rd_data is the entry at offset idx_r - 1.
        wr_en = 1'b1;
        if (shift_on) begin
          wr_data = rd_data;
          idx_nxt = idx_r - AW'(1);
          if (idx_r == AW'(1)) begin
            state_nxt = satq_pkg::S_INS_PUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = phys(head_r, idx_r - AW'(2));
          end
        end else begin
          count_nxt = count_r + CW'(1);
          state_nxt = satq_pkg::S_EMIT;
        end
      end

      satq_pkg::S_INS_PUT: begin
        wr_en     = 1'b1;
        count_nxt = count_r + CW'(1);
        state_nxt = satq_pkg::S_EMIT;
      end

      satq_pkg::S_EMIT: begin
        if (out_free) begin
          emit.vld        = 1'b1;
          emit.res.status = status_r;
          emit.res.tag    = tag_r;
          emit.res.delay  = delay_r;
          emit.res.last   = 1'b1;
          state_nxt       = satq_pkg::S_IDLE;
        end
      end

      satq_pkg::S_TK_CMP: begin
        // The previous popped entry waits in pend_r until it is known
        // whether another one follows it.
        if (due) begin
          if (pop) begin
            if (n_r != '0) begin
              emit.vld        = 1'b1;
              emit.res.status = satq_pkg::ST_FIRED;
              emit.res.tag    = pend_r.tag;
              emit.res.delay  = pend_r.delay;
              emit.res.last   = 1'b0;
            end
            pend_nxt  = rd_data;
            head_nxt  = phys(head_r, AW'(1));
            count_nxt = count_r - CW'(1);
            n_nxt     = n_r + satq_pkg::NW'(1);
            if ((count_r != CW'(1)) &&
                (n_r != satq_pkg::NW'(satq_pkg::MAX_OUT - 1))) begin
              rd_en   = 1'b1;
              rd_addr = phys(head_r, AW'(1));
            end else begin
              state_nxt = satq_pkg::S_TK_FLUSH;
            end
          end
        end else if (n_r != '0) begin
          state_nxt = satq_pkg::S_TK_FLUSH;
        end else begin
          state_nxt = satq_pkg::S_IDLE;
        end
      end

      satq_pkg::S_TK_FLUSH: begin
        if (out_free) begin
          emit.vld        = 1'b1;
          emit.res.status = satq_pkg::ST_FIRED;
          emit.res.tag    = pend_r.tag;
          emit.res.delay  = pend_r.delay;
          emit.res.last   = 1'b1;
          state_nxt       = satq_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = satq_pkg::S_IDLE;
      end
    endcase
  end

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above queue depth");

  a_n_max: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= satq_pkg::NW'(satq_pkg::MAX_OUT))
    else $error("too many alarms fired in one tick");

  a_ins_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == satq_pkg::S_INS_CMP) |-> (idx_r != '0) && (CW'(idx_r) <= count_r))
    else $error("insert walk index out of range");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> count_r == $past(count_r) - CW'(1))
    else $error("pop did not shrink the queue");

  a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write hit the same entry");

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sorted alarm timer queue
// Drives insert and tick words through the input stream, predicts every
// result word from a shadow copy of the sorted queue and compares them.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = satq_pkg::QUEUE_DEPTH_DEF;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_WAIT = 48;
  localparam int N_RANDOM   = 345;

  typedef struct packed {
    logic        op;
    logic [15:0] dly;
    logic [15:0] tag;
  } alarm_req_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  sorted_alarm_timer_queue_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Words still to be sent, and the result words the queue owes us.
  alarm_req_t     pending_reqs[$];
  satq_pkg::res_t alarm_results_due[$];

  // Shadow of the block: current second and the sorted pending alarms.
  logic [31:0]      shadow_now = '0;
  satq_pkg::entry_t shadow_alarms[$];

  int n_total     = 0;
  int n_accepted  = 0;
  int n_ticks     = 0;
  int n_results   = 0;
  int n_fired     = 0;
  int n_dropped   = 0;
  int n_errors    = 0;
  int peak_depth  = 0;
  bit quiet_run   = 1'b0;

  function automatic void add_req(logic op, logic [15:0] d, logic [15:0] t);
    alarm_req_t r;
    r.op  = op;
    r.dly = d;
    r.tag = t;
    pending_reqs.push_back(r);
    n_total++;
  endfunction

  // Mostly short gaps, some longer ones, none at all during a quiet run.
  function automatic int idle_len();
    int r = $urandom_range(0, 99);
    if (quiet_run) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Wrapping deadline order: a is earlier than b when a - b is negative.
  function automatic bit is_earlier(logic [31:0] a, logic [31:0] b);
    logic [31:0] diff;
    diff = a - b;
    return diff[31];
  endfunction

  function automatic satq_pkg::res_t make_res(satq_pkg::status_t s, logic [15:0] t,
                                              logic [15:0] d, logic l);
    satq_pkg::res_t r;
    r.status = s;
    r.tag    = t;
    r.delay  = d;
    r.last   = l;
    return r;
  endfunction

  // Works out the result words of one accepted input word.
  function automatic void track_alarm(logic op, logic [15:0] dly, logic [15:0] tag);
    satq_pkg::entry_t e;
    satq_pkg::res_t   r;
    int               pos;
    int               n;
    logic [31:0]      dl;
    if (op == satq_pkg::OP_INSERT) begin
      if (dly == 16'd0) begin
        alarm_results_due.push_back(make_res(satq_pkg::ST_FIRED, tag, 16'd0, 1'b1));
        n_fired++;
      end else if (shadow_alarms.size() >= DEPTH) begin
        alarm_results_due.push_back(make_res(satq_pkg::ST_DROPPED, tag, dly, 1'b1));
        n_dropped++;
      end else begin
        dl  = shadow_now + 32'(dly);
        pos = shadow_alarms.size();
        // The newer alarm goes ahead of any with the same deadline.
        for (int i = shadow_alarms.size() - 1; i >= 0; i--) begin
          if (!is_earlier(shadow_alarms[i].deadline, dl)) pos = i;
        end
        e.deadline = dl;
        e.tag      = tag;
        e.delay    = dly;
        shadow_alarms.insert(pos, e);
        if (shadow_alarms.size() > peak_depth) peak_depth = shadow_alarms.size();
        alarm_results_due.push_back(make_res(satq_pkg::ST_QUEUED, tag, dly, 1'b1));
      end
    end else begin
      shadow_now = shadow_now + 32'd1;
      n = 0;
      while (n < satq_pkg::MAX_OUT && shadow_alarms.size() > 0 &&
             !is_earlier(shadow_now, shadow_alarms[0].deadline)) begin
        e = shadow_alarms.pop_front();
        alarm_results_due.push_back(make_res(satq_pkg::ST_FIRED, e.tag, e.delay, 1'b0));
        n++;
      end
      n_fired += n;
      if (n > 0) begin
        r      = alarm_results_due[alarm_results_due.size() - 1];
        r.last = 1'b1;
        alarm_results_due[alarm_results_due.size() - 1] = r;
      end
    end
  endfunction

  // Random traffic: short delays with ticks so alarms actually fire, bursts
  // that fill the queue, and a few far-off or zero-delay alarms.
  task automatic queue_random_traffic(int n_items);
    int made;
    int r;
    int k;
    made = 0;
    while (made < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        k = $urandom_range(8, 18);
        repeat (k) add_req(satq_pkg::OP_INSERT, 16'($urandom_range(1, 4)), 16'($urandom));
        made += k;
        k = $urandom_range(1, 4);
        repeat (k) add_req(satq_pkg::OP_TICK, 16'($urandom), 16'($urandom));
        made += k;
      end else begin
        if (r < 42) begin
          add_req(satq_pkg::OP_TICK, 16'($urandom), 16'($urandom));
        end else if (r < 46) begin
          add_req(satq_pkg::OP_INSERT, 16'd0, 16'($urandom));
        end else if (r < 51) begin
          add_req(satq_pkg::OP_INSERT, 16'($urandom_range(5, 40)), 16'($urandom));
        end else if (r < 53) begin
          add_req(satq_pkg::OP_INSERT, 16'($urandom), 16'($urandom));
        end else begin
          add_req(satq_pkg::OP_INSERT, 16'($urandom_range(1, 12)), 16'($urandom));
        end
        made++;
      end
    end
  endtask

  // Input side: hold each word until the block takes it, then maybe idle.
  always @(posedge clk) begin : in_drive
    alarm_req_t req;
    bit         holding;
    int         gap;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap = 0;
    end else begin
      holding = in_tvalid;
      if (in_tvalid && in_tready) begin
        track_alarm(in_tuser[0], in_tdata[15:0], in_tdata[31:16]);
        if (in_tuser[0] == satq_pkg::OP_TICK) n_ticks++;
        n_accepted++;
        holding = 1'b0;
      end
      if (!holding) begin
        if (gap > 0) begin
          gap--;
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= req.op;
          in_tdata  <= {req.tag, req.dly};
          if ($urandom_range(0, 39) == 0) quiet_run = ~quiet_run;
          gap = idle_len();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: check each taken word against the oldest expectation.
  always @(posedge clk) begin : out_check
    satq_pkg::res_t want;
    int             stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_results++;
        if (alarm_results_due.size() == 0) begin
          $error("unexpected result word: status %0d tag %0d delay %0d last %0b",
                 out_tuser, out_tdata[15:0], out_tdata[31:16], out_tlast);
          n_errors++;
        end else begin
          want = alarm_results_due.pop_front();
          if (out_tuser !== 2'(want.status)) begin
            $error("status: expected %0d, got %0d", want.status, out_tuser);
            n_errors++;
          end
          if (out_tdata[15:0] !== want.tag) begin
            $error("fired_tag: expected %0d, got %0d", want.tag, out_tdata[15:0]);
            n_errors++;
          end
          if (out_tdata[31:16] !== want.delay) begin
            $error("fired_delay: expected %0d, got %0d", want.delay, out_tdata[31:16]);
            n_errors++;
          end
          if (out_tlast !== want.last) begin
            $error("last_result: expected %0b, got %0b", want.last, out_tlast);
            n_errors++;
          end
        end
      end
      if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = idle_len();
      end
    end
  end

  // Watchdog: too long without any word moving on either side.
  always @(posedge clk) begin : watchdog
    int idle;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle = 0;
    end else begin
      idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("timeout: %0d of %0d words taken, %0d results still owed",
                 n_accepted, n_total, alarm_results_due.size());
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin
    // Directed part: zero delay, the widest delay and tag, a tie between
    // equal deadlines, a tick with nothing due, then a full queue with a
    // drop, a zero-delay alarm while full and one tick firing fifteen.
    add_req(satq_pkg::OP_INSERT, 16'd0, 16'd0);
    add_req(satq_pkg::OP_INSERT, 16'hFFFF, 16'hFFFF);
    add_req(satq_pkg::OP_INSERT, 16'd2, 16'h00A1);
    add_req(satq_pkg::OP_INSERT, 16'd2, 16'h00B2);
    add_req(satq_pkg::OP_INSERT, 16'd1, 16'h0C03);
    add_req(satq_pkg::OP_TICK, 16'd0, 16'd0);
    add_req(satq_pkg::OP_TICK, 16'hFFFF, 16'hFFFF);
    add_req(satq_pkg::OP_TICK, 16'h5A5A, 16'hA5A5);
    for (int i = 0; i < DEPTH - 1; i++) begin
      add_req(satq_pkg::OP_INSERT, 16'd1, 16'(16'h8000 + i));
    end
    add_req(satq_pkg::OP_INSERT, 16'd7, 16'h7777);
    add_req(satq_pkg::OP_INSERT, 16'd0, 16'h5555);
    add_req(satq_pkg::OP_TICK, 16'd0, 16'd0);
    queue_random_traffic(N_RANDOM);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    wait (n_accepted == n_total);
    while (alarm_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("run: %0d words sent (%0d ticks), %0d results checked",
             n_accepted, n_ticks, n_results);
    $display("run: %0d alarms fired, %0d dropped as full, queue peaked at %0d",
             n_fired, n_dropped, peak_depth);
    if (n_errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/satq_pkg.sv
src/satq_ram.sv
src/satq_ctrl.sv
src/sorted_alarm_timer_queue_unit.sv
bench/tb.sv
